// ===== sv/b96dd_pkg.sv =====
// Package with shared constants, types and helpers for the 96-bit binary-to-decimal converter.
`timescale 1ns / 1ps
`default_nettype none
package b96dd_pkg;

    localparam int NUM_DIGITS  = 32;
    localparam int MANT_BITS   = 96;
    localparam int WORD_W      = 32;
    localparam int DIGIT_W     = 4;
    localparam int DPOS_W      = 5;
    localparam int SCALE_W     = 8;
    localparam int SIGN_BIT    = 31;
    localparam int SCALE_LSB   = 16;
    localparam int BCD_W       = DIGIT_W * NUM_DIGITS;
    localparam int CNT_W       = $clog2(MANT_BITS);
    localparam int POS_W       = $clog2(NUM_DIGITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified record waiting for conversion.
    typedef struct packed {
        logic [MANT_BITS-1:0] mant;
        logic                 negative;
        logic [SCALE_W-1:0]   scale;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DONE
    } t_conv_state;

    // Adds three to every digit of five or more, so that the following left
    // shift doubles each digit with a decimal carry into its neighbor.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0]   r;
        logic [DIGIT_W-1:0] d;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            d = v[i*DIGIT_W +: DIGIT_W];
            r[i*DIGIT_W +: DIGIT_W] = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/b96dd_if.sv =====
// Valid/ready channel interfaces for the input records and the output digits.
`timescale 1ns / 1ps
`default_nettype none
interface b96dd_in_if;
    import b96dd_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] mant_low;
    logic [WORD_W-1:0] mant_mid;
    logic [WORD_W-1:0] mant_high;
    logic [WORD_W-1:0] flags_word;

    modport source (output valid, mant_low, mant_mid, mant_high, flags_word, input ready);
    modport sink (input valid, mant_low, mant_mid, mant_high, flags_word, output ready);
endinterface

interface b96dd_out_if;
    import b96dd_pkg::*;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic [DPOS_W-1:0]  digit_pos;
    logic               negative;
    logic [SCALE_W-1:0] scale;
    logic               last;

    modport source (output valid, digit, digit_pos, negative, scale, last, input ready);
    modport sink (input valid, digit, digit_pos, negative, scale, last, output ready);
endinterface
`default_nettype wire

// ===== sv/b96dd_front.sv =====
// Front stage: accepts input records, extracts mantissa, sign and scale, and pushes them on.
`timescale 1ns / 1ps
`default_nettype none
module b96dd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    b96dd_in_if.sink            i_in,
    output b96dd_pkg::t_item    o_item,
    output logic                o_push,
    input  wire logic           i_q_ready
);
    import b96dd_pkg::*;

    logic                   r_valid;
    t_item                  r_item;
    t_item                  n_item;
    logic [3*WORD_W-1:0]    w_full;
    logic                   w_take;

    assign w_full = {i_in.mant_high, i_in.mant_mid, i_in.mant_low};

    always_comb begin
        n_item.mant     = w_full[MANT_BITS-1:0];
        n_item.negative = i_in.flags_word[SIGN_BIT];
        n_item.scale    = i_in.flags_word[SCALE_LSB +: SCALE_W];
    end

    assign i_in.ready = !r_valid || i_q_ready;
    assign w_take     = i_in.valid && i_in.ready;
    assign o_push     = r_valid && i_q_ready;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

// ===== sv/b96dd_queue.sv =====
// Short queue of classified records between the front stage and the converter.
`timescale 1ns / 1ps
`default_nettype none
module b96dd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire b96dd_pkg::t_item i_item,
    input  wire logic           i_push,
    output logic                o_ready,
    output b96dd_pkg::t_item    o_item,
    output logic                o_valid,
    input  wire logic           i_pop
);
    import b96dd_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_wr;
    logic                w_rd;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== sv/b96dd_conv.sv =====
// Back end: shift-and-add-3 conversion, one mantissa bit per cycle, and digit emission.
`timescale 1ns / 1ps
`default_nettype none
module b96dd_conv (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire b96dd_pkg::t_item i_item,
    input  wire logic             i_valid,
    output logic                  o_pop,
    b96dd_out_if.source           o_out
);
    import b96dd_pkg::*;

    localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(MANT_BITS - 1);
    localparam logic [POS_W-1:0] LAST_DIGIT = POS_W'(NUM_DIGITS - 1);

    t_conv_state           r_state;
    t_conv_state           n_state;
    logic                  w_load;
    logic                  w_step;
    logic                  w_hand;

    // Conversion registers
    logic [MANT_BITS-1:0]  r_mant;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      w_adj;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_neg;
    logic [SCALE_W-1:0]    r_scale;

    // Emission registers
    logic                  r_emit_busy;
    logic [BCD_W-1:0]      r_emit_bcd;
    logic [POS_W-1:0]      r_emit_k;
    logic                  r_emit_neg;
    logic [SCALE_W-1:0]    r_emit_scale;
    logic                  w_emit;

    // Output register
    logic                  r_out_valid;
    logic [DIGIT_W-1:0]    r_out_digit;
    logic [DPOS_W-1:0]     r_out_pos;
    logic                  r_out_neg;
    logic [SCALE_W-1:0]    r_out_scale;
    logic                  r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_step  = 1'b0;
        w_hand  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_load  = 1'b1;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_step = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_emit_busy) begin
                    w_hand  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_pop = w_load;

    // The top bit of the adjusted value is the decimal carry out of the top digit.
    assign w_adj = bcd_adjust(r_bcd);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mant  <= i_item.mant;
            r_neg   <= i_item.negative;
            r_scale <= i_item.scale;
            r_bcd   <= '0;
            r_cnt   <= '0;
        end else if (w_step) begin
            r_mant <= {r_mant[MANT_BITS-2:0], 1'b0};
            r_bcd  <= {w_adj[BCD_W-2:0], r_mant[MANT_BITS-1]};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    // A digit moves to the output register whenever that register is free
    // or its contents are being transferred in this cycle.
    assign w_emit = r_emit_busy && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_busy <= 1'b0;
        end else if (w_hand) begin
            r_emit_busy <= 1'b1;
        end else if (w_emit && r_emit_k == LAST_DIGIT) begin
            r_emit_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hand) begin
            r_emit_bcd   <= r_bcd;
            r_emit_k     <= '0;
            r_emit_neg   <= r_neg;
            r_emit_scale <= r_scale;
        end else if (w_emit) begin
            r_emit_bcd <= {r_emit_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            r_emit_k   <= r_emit_k + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_digit <= r_emit_bcd[BCD_W-1 -: DIGIT_W];
            r_out_pos   <= DPOS_W'(r_emit_k);
            r_out_neg   <= r_emit_neg;
            r_out_scale <= r_emit_scale;
            r_out_last  <= (r_emit_k == LAST_DIGIT);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.digit     = r_out_digit;
    assign o_out.digit_pos = r_out_pos;
    assign o_out.negative  = r_out_neg;
    assign o_out.scale     = r_out_scale;
    assign o_out.last      = r_out_last;

    // The converter never runs past the last mantissa bit.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |-> r_cnt <= LAST_STEP)
        else $error("bit counter beyond mantissa width");

    // After the last bit the result waits for the emitter.
    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV && r_cnt == LAST_STEP |=> r_state == S_DONE)
        else $error("conversion did not end after the last bit");

    // A finished result is never handed over while digits are still going out.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_emit_busy |=> r_state == S_DONE)
        else $error("result handed over while emitter busy");
endmodule
`default_nettype wire

// ===== sv/binary96_to_decimal_digits_top.sv =====
// Top level: 96-bit binary mantissa to a run of 32 decimal digits with sign and scale.
// Path: a record passes the front register, the queue, the converter load, one shift-and-add-3
// step per mantissa bit, the handover and the output register before its first digit is presented.
// Records are paced by the one-bit-per-cycle conversion loop; the 32 digits of a record go out
// one per cycle, unless the output stalls, while the next record is converted.
// Reset: synchronous, active low; it empties the front register, queue, converter and output.
`timescale 1ns / 1ps
`default_nettype none
module binary96_to_decimal_digits_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b96dd_in_if.sink    i_in,
    b96dd_out_if.source o_out
);
    import b96dd_pkg::*;

    t_item  w_front_item;
    logic   w_push;
    logic   w_q_ready;
    t_item  w_q_item;
    logic   w_q_valid;
    logic   w_pop;

    b96dd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_item    (w_front_item),
        .o_push    (w_push),
        .i_q_ready (w_q_ready)
    );

    b96dd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_front_item),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .o_item  (w_q_item),
        .o_valid (w_q_valid),
        .i_pop   (w_pop)
    );

    b96dd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_q_item),
        .i_valid (w_q_valid),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
